[rtl/wac_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wac_pkg
// Shared constants and types of the weighted approximate counter: field
// widths, count geometry and the item record passed from front to back.
// ----------------------------------------------------------------------------
package wac_pkg;

  // Field widths of one transaction.
  localparam int WeightBits   = 16;
  localparam int RandomBits   = 32;
  localparam int ExpBits      = 5;
  localparam int CountOutBits = 16;
  localparam int EstimateBits = 47;

  // Counter geometry.
  localparam int CountBits   = 16;
  localparam int MaxExponent = 31;

  // One weight shifted down, plus a possible round-up.
  localparam int IncBits = WeightBits + 1;
  // Count plus increment, with a carry bit.
  localparam int SumBits = ((CountBits > IncBits) ? CountBits : IncBits) + 1;
  // Count shifted left by the largest exponent the field can hold.
  localparam int ShiftedBits = CountBits + (1 << ExpBits) - 1;

  localparam logic [SumBits-1:0]   CountMaxSum = SumBits'({CountBits{1'b1}});
  localparam logic [CountBits-1:0] CountMax    = {CountBits{1'b1}};
  localparam logic [ExpBits-1:0]   ExpMax      = ExpBits'(MaxExponent);

  // Decoupling queue between the front and the back.
  localparam int QueueDepth    = 2;
  localparam int QueuePtrBits  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QueueCntBits  = $clog2(QueueDepth + 1);

  // Item as classified by the front.
  typedef struct packed {
    logic [WeightBits-1:0] weight;
    logic [RandomBits-1:0] random_bits;
    logic                  last;
    logic                  zero_weight;
  } item_t;

endpackage : wac_pkg
`default_nettype wire

[rtl/wac_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wac_front
// Input stage: registers each incoming transaction, tags it and offers it to
// the decoupling queue.
// ----------------------------------------------------------------------------
module wac_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [wac_pkg::WeightBits-1:0] weight,
  input  wire logic [wac_pkg::RandomBits-1:0] random_bits,
  input  wire logic                           end_of_run,
  output logic                                item_valid,
  input  wire logic                           item_stall,
  output wac_pkg::item_t                      item
);
  import wac_pkg::*;

  logic  front_valid;
  logic  front_valid_next;
  item_t front_item;
  logic  load;
  logic  push;

  assign push     = front_valid && !item_stall;
  assign in_stall = front_valid && item_stall;
  assign load     = in_valid && !in_stall;

  always_comb begin
    front_valid_next = front_valid;
    if (load) begin
      front_valid_next = 1'b1;
    end else if (push) begin
      front_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else begin
      front_valid <= front_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      front_item.weight      <= weight;
      front_item.random_bits <= random_bits;
      front_item.last        <= end_of_run;
      front_item.zero_weight <= (weight == '0);
    end
  end

  assign item_valid = front_valid;
  assign item       = front_item;

endmodule : wac_front
`default_nettype wire

[rtl/wac_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wac_queue
// Short first-in first-out queue that lets the front and the back stall
// independently of each other.
// ----------------------------------------------------------------------------
module wac_queue (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push_valid,
  output logic        push_stall,
  input  wire wac_pkg::item_t push_item,
  output logic        pop_valid,
  input  wire logic   pop_stall,
  output wac_pkg::item_t pop_item
);
  import wac_pkg::*;

  item_t                   entries [QueueDepth];
  logic [QueuePtrBits-1:0] wr_ptr;
  logic [QueuePtrBits-1:0] rd_ptr;
  logic [QueueCntBits-1:0] fill;
  logic [QueueCntBits-1:0] fill_next;
  logic                    push;
  logic                    pop;

  assign push_stall = (fill == QueueCntBits'(QueueDepth));
  assign pop_valid  = (fill != '0);
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;
  assign pop_item   = entries[rd_ptr];

  always_comb begin
    fill_next = fill;
    if (push && !pop) begin
      fill_next = fill + QueueCntBits'(1);
    end else if (pop && !push) begin
      fill_next = fill - QueueCntBits'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      fill <= fill_next;
      if (push) begin
        wr_ptr <= (wr_ptr == QueuePtrBits'(QueueDepth - 1)) ? '0 : wr_ptr + QueuePtrBits'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QueuePtrBits'(QueueDepth - 1)) ? '0 : rd_ptr + QueuePtrBits'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // The fill level never goes beyond the number of entries.
  assert property (@(posedge clk) disable iff (rst)
    fill <= QueueCntBits'(QueueDepth))
    else $error("queue fill level beyond its depth");

  // When the queue is empty or full, the two pointers are equal.
  assert property (@(posedge clk) disable iff (rst)
    (fill == '0 || fill == QueueCntBits'(QueueDepth)) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with fill level");

  // A push into a full queue is refused, so fill holds when nothing pops.
  assert property (@(posedge clk) disable iff (rst)
    (push_stall && !pop) |=> (fill == QueueCntBits'(QueueDepth)))
    else $error("full queue lost its contents");

endmodule : wac_queue
`default_nettype wire

[rtl/wac_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wac_back
// Update stage: applies one item to the count and exponent, and holds the
// result in an output register until it is taken.
// ----------------------------------------------------------------------------
module wac_back (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             item_valid,
  output logic                                  item_stall,
  input  wire wac_pkg::item_t                   item,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [wac_pkg::CountOutBits-1:0]      count_value,
  output logic [wac_pkg::ExpBits-1:0]           scale_exponent,
  output logic [wac_pkg::EstimateBits-1:0]      estimate,
  output logic                                  saturated
);
  import wac_pkg::*;

  // Running state.
  logic [CountBits-1:0]  count;
  logic [ExpBits-1:0]    exponent;
  logic                  sat_flag;
  logic [CountBits-1:0]  count_next;
  logic [ExpBits-1:0]    exponent_next;
  logic                  sat_flag_next;

  // Output register.
  logic [CountBits-1:0]  res_count;
  logic [ExpBits-1:0]    res_exponent;
  logic                  res_sat;

  logic                  take;
  logic [WeightBits-1:0] rem_mask;
  logic [WeightBits-1:0] rem;
  logic [RandomBits-1:0] threshold;
  logic [ExpBits:0]      thr_shift;
  logic                  round_up;
  logic [IncBits-1:0]    inc;
  logic [SumBits-1:0]    sum;
  logic [SumBits-1:0]    half;

  assign item_stall = out_valid && out_stall;
  assign take       = item_valid && !item_stall;

  // Increment is the weight shifted down by k; the dropped fraction rounds
  // up when the random word falls strictly below it, scaled to 32 bits.
  assign rem_mask  = ~({WeightBits{1'b1}} << exponent);
  assign rem       = item.weight & rem_mask;
  assign thr_shift = (ExpBits + 1)'(RandomBits) - {1'b0, exponent};
  assign threshold = (exponent == '0) ? '0
                   : RandomBits'(RandomBits'(rem) << thr_shift);
  assign round_up  = !item.zero_weight && (item.random_bits < threshold);
  assign inc       = IncBits'(item.weight >> exponent) + IncBits'(round_up);
  assign sum       = SumBits'(count) + SumBits'(inc);
  assign half      = sum >> 1;

  always_comb begin
    count_next    = count;
    exponent_next = exponent;
    sat_flag_next = sat_flag;
    priority if (sum <= CountMaxSum) begin
      count_next = CountBits'(sum);
    end else if (exponent < ExpMax) begin
      exponent_next = exponent + ExpBits'(1);
      count_next    = (half > CountMaxSum) ? CountMax : CountBits'(half);
    end else begin
      count_next    = CountMax;
      sat_flag_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      exponent  <= '0;
      sat_flag  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        out_valid <= 1'b1;
        if (item.last) begin
          count    <= '0;
          exponent <= '0;
          sat_flag <= 1'b0;
        end else begin
          count    <= count_next;
          exponent <= exponent_next;
          sat_flag <= sat_flag_next;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_count    <= count_next;
      res_exponent <= exponent_next;
      res_sat      <= sat_flag_next;
    end
  end

  assign count_value    = CountOutBits'(res_count);
  assign scale_exponent = res_exponent;
  assign estimate       = EstimateBits'(ShiftedBits'(res_count) << res_exponent);
  assign saturated      = res_sat;

  // An end-of-run item leaves the state cleared for the next run.
  assert property (@(posedge clk) disable iff (rst)
    (take && item.last) |=> (count == '0 && exponent == '0 && !sat_flag))
    else $error("state not cleared after end of run");

  // Within a run the exponent never falls.
  assert property (@(posedge clk) disable iff (rst)
    (take && !item.last) |=> (exponent >= $past(exponent)))
    else $error("exponent decreased within a run");

  // Saturation can only happen once the exponent has reached its maximum.
  assert property (@(posedge clk) disable iff (rst)
    sat_flag |-> (exponent == ExpMax && count == CountMax))
    else $error("saturation flag set below the maximum exponent");

  // The state moves only when an item is taken.
  assert property (@(posedge clk) disable iff (rst)
    !take |=> ($stable(count) && $stable(exponent) && $stable(sat_flag)))
    else $error("counter state changed without an item");

endmodule : wac_back
`default_nettype wire

[rtl/weighted_approximate_counter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_approximate_counter
// Path: an accepted input transaction passes the input register, the queue
// and the update with output register before its result is offered.
// Throughput: one transaction per cycle while the output is not stalled;
// the back stage updates count and exponent for each item it takes.
// Reset: synchronous; clears count, exponent, flag and all valid state.
// ----------------------------------------------------------------------------
//
// Weighted probabilistic approximate counter. Each transaction carries a
// weight and a fresh random word. The block keeps a compressed count and a
// scale exponent k, so that the estimated weight sum is count * 2^k.
//
// Structure:
//   wac_front  registers the incoming transaction and tags it (end of run,
//              zero weight).
//   wac_queue  a two-entry queue, so that a stall at the output does not
//              immediately stall the input, and vice versa.
//   wac_back   adds weight >> k to the count, rounding up with probability
//              equal to the dropped fraction. On overflow the exponent is
//              raised and the count halved; at the maximum exponent the count
//              saturates and a sticky flag is set. The result is held in an
//              output register, and the back takes the next item in the same
//              cycle in which the current result is taken.
//
// An end-of-run transaction is counted and reported as usual; the state then
// returns to zero for the next run.
module weighted_approximate_counter (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [wac_pkg::WeightBits-1:0]   weight,
  input  wire logic [wac_pkg::RandomBits-1:0]   random_bits,
  input  wire logic                             end_of_run,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [wac_pkg::CountOutBits-1:0]      count_value,
  output logic [wac_pkg::ExpBits-1:0]           scale_exponent,
  output logic [wac_pkg::EstimateBits-1:0]      estimate,
  output logic                                  saturated
);
  import wac_pkg::*;

  // Front to queue.
  logic  front_valid;
  logic  front_stall;
  item_t front_item;

  // Queue to back.
  logic  queue_valid;
  logic  queue_stall;
  item_t queue_item;

  wac_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .weight      (weight),
    .random_bits (random_bits),
    .end_of_run  (end_of_run),
    .item_valid  (front_valid),
    .item_stall  (front_stall),
    .item        (front_item)
  );

  wac_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_stall (front_stall),
    .push_item  (front_item),
    .pop_valid  (queue_valid),
    .pop_stall  (queue_stall),
    .pop_item   (queue_item)
  );

  wac_back u_back (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (queue_valid),
    .item_stall     (queue_stall),
    .item           (queue_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .count_value    (count_value),
    .scale_exponent (scale_exponent),
    .estimate       (estimate),
    .saturated      (saturated)
  );

endmodule : weighted_approximate_counter
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the weighted approximate counter. A shadow copy of
// count, exponent and saturation flag predicts every report. Directed tests
// cover the edges of the rounding and overflow rules. Random runs of weights
// then drive the exponent well up, with bursty input and a stalling output.
// ----------------------------------------------------------------------------
module tb_top;
  import wac_pkg::*;

  // The limit is a comfortable margin over the slowest legal run, not a tight bound.
  localparam int LimitCycles  = 400000;
  // The drain allows several times over for the output latency.
  localparam int DrainCycles  = 20;
  localparam int RandomItems  = 1930;

  // One report of the counter as it should appear on the output side.
  typedef struct packed {
    logic [CountOutBits-1:0] count;
    logic [ExpBits-1:0]      exponent;
    logic [EstimateBits-1:0] estimate;
    logic                    sat;
  } count_report_t;

  // Behaviours of the output side; each is held for a random stretch.
  typedef enum logic [1:0] {
    StallNone,
    StallLight,
    StallHeavy,
    StallAlternate
  } stall_mode_e;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [WeightBits-1:0] weight = '0;
  logic [RandomBits-1:0] random_bits = '0;
  logic                  end_of_run = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CountOutBits-1:0] count_value;
  logic [ExpBits-1:0]      scale_exponent;
  logic [EstimateBits-1:0] estimate;
  logic                    saturated;

  weighted_approximate_counter dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .weight        (weight),
    .random_bits   (random_bits),
    .end_of_run    (end_of_run),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .count_value   (count_value),
    .scale_exponent(scale_exponent),
    .estimate      (estimate),
    .saturated     (saturated)
  );

  // Shadow state of the counter. It is advanced when a transaction is
  // accepted, so it always reflects every transaction sent so far.
  logic [63:0]        shadow_count = '0;
  logic [ExpBits-1:0] shadow_exp = '0;
  logic               shadow_sat = 1'b0;

  count_report_t pending_reports[$];
  int            mismatch_count = 0;
  int            cycle_count = 0;

  // Sender pacing: bursts of random length separated by random gaps. The
  // gaps can be switched off so that back-to-back stretches occur as well.
  int            burst_left = 0;
  bit            gaps_on = 1'b1;

  stall_mode_e   stall_mode = StallNone;
  int            stall_phase_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LimitCycles) begin
      $display("%0t ns: timeout with %0d reports outstanding", $time,
               pending_reports.size());
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Round-up threshold: the dropped fraction of the weight scaled to 32 bits.
  // At exponent zero nothing is dropped, so the random word cannot matter.
  function automatic logic [63:0] round_threshold(logic [WeightBits-1:0] w,
                                                  logic [ExpBits-1:0] k);
    logic [63:0] rem;
    rem = 64'(w) & ((64'd1 << k) - 64'd1);
    if (k == 0) begin
      return 64'd0;
    end
    return rem << (32 - k);
  endfunction

  // Applies one transaction to the shadow state and returns the report that
  // the counter must produce for it.
  function automatic count_report_t apply_weight(logic [WeightBits-1:0] w,
                                                 logic [RandomBits-1:0] rnd,
                                                 logic last);
    logic [63:0]   inc;
    logic [63:0]   sum;
    logic [63:0]   shifted;
    count_report_t rep;
    inc = 64'(w) >> shadow_exp;
    if (64'(rnd) < round_threshold(w, shadow_exp)) begin
      inc = inc + 64'd1;
    end
    sum = shadow_count + inc;
    if (sum <= 64'(CountMax)) begin
      shadow_count = sum;
    end else if (shadow_exp < MaxExponent) begin
      // Overflow: one more bit of scale, and the count halves.
      shadow_exp = shadow_exp + 1'b1;
      sum = sum >> 1;
      shadow_count = (sum > 64'(CountMax)) ? 64'(CountMax) : sum;
    end else begin
      shadow_count = 64'(CountMax);
      shadow_sat = 1'b1;
    end
    shifted = shadow_count << shadow_exp;
    rep.count = shadow_count[CountOutBits-1:0];
    rep.exponent = shadow_exp;
    rep.estimate = shifted[EstimateBits-1:0];
    rep.sat = shadow_sat;
    // The report shows the state after the item; only then is it cleared.
    if (last) begin
      shadow_count = '0;
      shadow_exp = '0;
      shadow_sat = 1'b0;
    end
    return rep;
  endfunction

  // Offers one transaction and holds it until accepted. Payload and valid
  // change only at the falling edge; acceptance is seen at the rising edge.
  task automatic send_item(logic [WeightBits-1:0] w, logic [RandomBits-1:0] rnd,
                           logic last);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(1, 8) : 0;
      burst_left = $urandom_range(1, 16);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    weight <= w;
    random_bits <= rnd;
    end_of_run <= last;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    pending_reports.push_back(apply_weight(w, rnd, last));
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, name,
               want, got);
      mismatch_count++;
    end
  endtask

  // Every report taken from the counter is held against the oldest
  // prediction still waiting.
  always @(posedge clk) begin : check_reports
    count_report_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $display("%0t ns: report with none expected: count %0d, exponent %0d",
                 $time, count_value, scale_exponent);
        mismatch_count++;
      end else begin
        want = pending_reports.pop_front();
        check_field("count_value", 64'(want.count), 64'(count_value));
        check_field("scale_exponent", 64'(want.exponent), 64'(scale_exponent));
        check_field("estimate", 64'(want.estimate), 64'(estimate));
        check_field("saturated", 64'(want.sat), 64'(saturated));
      end
    end
  end

  // The output side moves through its stall behaviours on a schedule of its
  // own, independent of the sender, so that stalls land on every phase.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_phase_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        stall_phase_left = $urandom_range(20, 200);
      end
      stall_phase_left--;
      case (stall_mode)
        StallNone: begin
          out_stall <= 1'b0;
        end
        StallLight: begin
          out_stall <= ($urandom_range(0, 99) < 25);
        end
        StallHeavy: begin
          out_stall <= ($urandom_range(0, 99) < 70);
        end
        default: begin
          out_stall <= ~out_stall;
        end
      endcase
    end
  end

  // At exponent zero the add is exact whatever the random word says. The
  // count is filled exactly to its top, then one more unit overflows it, and
  // that last transaction also ends the run.
  task automatic test_exact_add();
    send_item(16'h0000, 32'hFFFF_FFFF, 1'b0);
    send_item(16'h0001, 32'hFFFF_FFFF, 1'b0);
    send_item(16'h7FFF, 32'h0000_0000, 1'b0);
    send_item(16'h7FFF, 32'hAAAA_5555, 1'b0);
    send_item(16'h0000, 32'h0000_0000, 1'b0);
    send_item(16'h0001, 32'h5555_AAAA, 1'b1);
  endtask

  // Probabilistic rounding: the random word must lie strictly below the
  // scaled remainder, so the word equal to the threshold does not round up
  // and the one just below it does.
  task automatic test_rounding();
    send_item(16'hFFFF, 32'h0000_0000, 1'b0);
    send_item(16'h0001, 32'h0000_0000, 1'b0);
    send_item(16'h0001, 32'h8000_0000, 1'b0);
    send_item(16'h0001, 32'h7FFF_FFFF, 1'b0);
    send_item(16'hFFFF, 32'h0000_0000, 1'b0);
    send_item(16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    send_item(16'h0003, 32'hBFFF_FFFF, 1'b1);
  endtask

  // Repeated full weights overflow the count again and again and walk the
  // exponent upwards. Overflow at the maximum exponent needs a weight sum
  // near 2^47, some two thousand million transactions, so the saturation
  // path lies beyond any run of this length; with a 16-bit count half the
  // sum always fits, so the clamp after halving cannot fire either.
  task automatic test_exponent_climb();
    for (int i = 0; i < 10; i++) begin
      send_item(16'hFFFF, 32'h0000_0000, i == 9);
    end
  endtask

  function automatic logic [WeightBits-1:0] pick_weight(bit heavy);
    int sel;
    sel = $urandom_range(0, 9);
    if (heavy && sel < 6) begin
      return WeightBits'($urandom_range(16'hC000, 16'hFFFF));
    end
    case (sel)
      0: return '0;
      1: return '1;
      2: return WeightBits'($urandom_range(0, 15));
      default: return WeightBits'($urandom);
    endcase
  endfunction

  // Random words aimed at the rounding boundary for the exponent that the
  // item will meet, with plain random words most of the time.
  function automatic logic [RandomBits-1:0] pick_random(logic [WeightBits-1:0] w);
    logic [63:0] thr;
    thr = round_threshold(w, shadow_exp);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return thr[RandomBits-1:0];
      3: return RandomBits'(thr - 64'd1);
      default: return RandomBits'($urandom);
    endcase
  endfunction

  // Random runs, each closed by an end-of-run transaction. Most runs are
  // short; about one in five is long, and about two in three are weighted
  // heavily, which pushes the exponent to ten or so. A stray end-of-run now
  // and then cuts a run short. The last run is trimmed to keep the planned total.
  task automatic test_random_runs();
    int  sent;
    int  run_len;
    bit  heavy;
    logic [WeightBits-1:0] w;
    sent = 0;
    while (sent < RandomItems) begin
      run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(150, 500)
                                           : $urandom_range(1, 40);
      if (run_len > RandomItems - sent) begin
        run_len = RandomItems - sent;
      end
      heavy = ($urandom_range(0, 2) != 0);
      gaps_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < run_len; i++) begin
        w = pick_weight(heavy);
        send_item(w, pick_random(w), (i == run_len - 1) || ($urandom_range(0, 99) == 0));
      end
      sent += run_len;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_exact_add();
    test_rounding();
    test_exponent_climb();
    test_random_runs();

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) begin
      @(posedge clk);
    end
    // Any report beyond the last expected one shows up within the drain.
    repeat (DrainCycles) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
